// ===== hdl/sfd_pkg.sv =====
package sfd_pkg;

  // default build parameters
  localparam int SFD_LINE_DEPTH  = 65536;
  localparam int SFD_SAMPLE_BITS = 24;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_DELAY  = 3'd0,
    CFG_FEEDBACK_GAIN = 3'd1,
    CFG_DAMPING_COEFF = 3'd2,
    CFG_WET_MIX       = 3'd3,
    CFG_PING_PONG     = 3'd4
  } cfg_idx_e;

  // register reset values
  localparam logic [31:0] DELAY_RESET    = 32'd1228800000;
  localparam logic [15:0] FEEDBACK_RESET = 16'd26214;
  localparam logic [16:0] DAMPING_RESET  = 17'd19661;
  localparam logic [16:0] WET_RESET      = 17'd19661;

  // fixed point constants
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam int          GLIDE_STEP = 13;
  localparam int          ROUND_HALF = 32768;

  // shared multiply-accumulate unit, operands cover samples up to 32 bits
  localparam int MAC_X_W   = 33;
  localparam int MAC_Y_W   = 18;
  localparam int MAC_ACC_W = MAC_X_W + MAC_Y_W + 1;

  typedef struct packed {
    logic                 en;
    logic                 load;
    logic [MAC_ACC_W-1:0] bias;
    logic [MAC_X_W-1:0]   x;
    logic [MAC_Y_W-1:0]   y;
  } mac_req_t;

endpackage

// ===== hdl/sfd_if.sv =====
interface sfd_in_if import sfd_pkg::*; #(
  parameter int SAMPLE_BITS = SFD_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_in;
  logic [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface sfd_out_if import sfd_pkg::*; #(
  parameter int SAMPLE_BITS = SFD_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_out;
  logic [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

// ===== hdl/sfd_mac.sv =====
module sfd_mac import sfd_pkg::*; (
  input  logic                        clk_i,
  input  mac_req_t                    req_i,
  output logic signed [MAC_ACC_W-1:0] acc_o
);

  logic signed [MAC_X_W+MAC_Y_W-1:0] prod;
  logic signed [MAC_ACC_W-1:0]       base;
  logic signed [MAC_ACC_W-1:0]       acc_d;
  logic signed [MAC_ACC_W-1:0]       acc_q;

  // one signed product added to a fresh bias or to the running sum
  assign prod  = $signed(req_i.x) * $signed(req_i.y);
  assign base  = req_i.load ? $signed(req_i.bias) : acc_q;
  assign acc_d = base + MAC_ACC_W'(prod);

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== hdl/sfd_line.sv =====
module sfd_line import sfd_pkg::*; #(
  parameter  int DEPTH  = SFD_LINE_DEPTH,
  parameter  int WIDTH  = SFD_SAMPLE_BITS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/stereo_feedback_delay_top.sv =====
// channel   direction  handshake          payload
// in_i      sink       valid / ready      left_in, right_in (signed Q1.23)
// out_o     source     valid / ready      left_out, right_out (signed Q1.23)
// cfg       write      cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// an item is accepted only from idle, so a frame ends before the next accept:
// a single multiply-accumulate unit runs 13 passes per frame and the two
// delay lines, each with one read port, make the two interpolation reads in turn
// after reset both lines are swept to zero with ready low
// a result waiting on out_o does not block the next accept; the block stalls
// only at the end of the next frame until the output register is free
module stereo_feedback_delay_top import sfd_pkg::*; #(
  parameter int LINE_DEPTH  = SFD_LINE_DEPTH,
  parameter int SAMPLE_BITS = SFD_SAMPLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfd_in_if.sink                in_i,
  sfd_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int AW  = $clog2(LINE_DEPTH);
  localparam int SB  = SAMPLE_BITS;
  localparam int CW  = (AW + 16 > 32) ? AW + 16 : 32;
  localparam logic [CW-1:0] MIN_DELAY = CW'(ONE_Q16);
  localparam logic [CW-1:0] MAX_DELAY = CW'(LINE_DEPTH - 2) << 16;
  localparam logic [AW-1:0] LAST_ADDR = AW'(LINE_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X   = (AW+1)'(LINE_DEPTH);
  localparam logic signed [MAC_ACC_W-1:0] SAT_MAX =
    (MAC_ACC_W'(1) << (SAMPLE_BITS - 1)) - MAC_ACC_W'(1);
  localparam logic signed [MAC_ACC_W-1:0] SAT_MIN = -SAT_MAX - MAC_ACC_W'(1);

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_CLEAR = 22'h000002,
    S_GLIDE = 22'h000004,
    S_ADJ   = 22'h000008,
    S_ADDR  = 22'h000010,
    S_RD0   = 22'h000020,
    S_RD1   = 22'h000040,
    S_RD2   = 22'h000080,
    S_IL    = 22'h000100,
    S_IR    = 22'h000200,
    S_OL0   = 22'h000400,
    S_OL1   = 22'h000800,
    S_OR0   = 22'h001000,
    S_OR1   = 22'h002000,
    S_DL0   = 22'h004000,
    S_DL1   = 22'h008000,
    S_DR0   = 22'h010000,
    S_DR1   = 22'h020000,
    S_FL    = 22'h040000,
    S_FR    = 22'h080000,
    S_WB    = 22'h100000,
    S_DONE  = 22'h200000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [31:0] target_q;
  logic [15:0] fbg_q;
  logic [16:0] damp_c_q;
  logic [16:0] wet_q;
  logic        pp_q;

  // control state
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [31:0]   glided_q, glided_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;

  // frame payload
  logic signed [SB-1:0] dry_l_q, dry_r_q;
  logic [AW-1:0]        ri_q, rj_q;
  logic [15:0]          frac_q;
  logic signed [SB-1:0] a_l_q, a_r_q;
  logic signed [SB:0]   dif_l_q, dif_r_q;
  logic signed [SB-1:0] del_l_q, del_r_q;
  logic signed [SB-1:0] dmp_l_q, dmp_r_q;
  logic signed [SB-1:0] res_l_q, res_r_q;
  logic [SB-1:0]        out_l_q, out_r_q;

  // shared arithmetic
  mac_req_t                    mac_req;
  logic signed [MAC_ACC_W-1:0] acc;
  logic signed [MAC_ACC_W-1:0] acc_shr;
  logic signed [SB-1:0]        acc_sat;
  logic signed [MAC_X_W-1:0]   glide_diff;
  logic [16:0]                 damp_eff, damp_inv, wet_eff, wet_inv;
  logic signed [SB-1:0]        fed_l, fed_r;

  // read address
  logic [CW-1:0]   glided_x, delay_c;
  logic [AW:0]     wp_ext, rd_int, rd_wrap;
  logic [AW+16:0]  rd_pos;

  // delay line ports
  logic          we_l, we_r;
  logic [AW-1:0] waddr, raddr;
  logic [SB-1:0] wdata_l, wdata_r, rdata_l, rdata_r;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= DELAY_RESET;
      fbg_q    <= FEEDBACK_RESET;
      damp_c_q <= DAMPING_RESET;
      wet_q    <= WET_RESET;
      pp_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET_DELAY:  target_q <= cfg_wdata_i[31:0];
        CFG_FEEDBACK_GAIN: fbg_q    <= cfg_wdata_i[15:0];
        CFG_DAMPING_COEFF: damp_c_q <= cfg_wdata_i[16:0];
        CFG_WET_MIX:       wet_q    <= cfg_wdata_i[16:0];
        CFG_PING_PONG:     pp_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // coefficients above one act as one
  assign damp_eff = (damp_c_q > ONE_Q16) ? ONE_Q16 : damp_c_q;
  assign wet_eff  = (wet_q > ONE_Q16) ? ONE_Q16 : wet_q;
  assign damp_inv = ONE_Q16 - damp_eff;
  assign wet_inv  = ONE_Q16 - wet_eff;

  assign fed_l = pp_q ? del_r_q : del_l_q;
  assign fed_r = pp_q ? del_l_q : del_r_q;

  assign glide_diff = $signed({1'b0, target_q}) - $signed({1'b0, glided_q});

  // floor of accumulator over 65536, then saturation to the sample range
  assign acc_shr = acc >>> 16;
  always_comb begin
    if (acc_shr > SAT_MAX) begin
      acc_sat = SAT_MAX[SB-1:0];
    end else if (acc_shr < SAT_MIN) begin
      acc_sat = SAT_MIN[SB-1:0];
    end else begin
      acc_sat = acc_shr[SB-1:0];
    end
  end

  // clamped delay and the integer and fraction of the read position
  always_comb begin
    glided_x = CW'(glided_q);
    if (glided_x < MIN_DELAY) begin
      delay_c = MIN_DELAY;
    end else if (glided_x > MAX_DELAY) begin
      delay_c = MAX_DELAY;
    end else begin
      delay_c = glided_x;
    end
    wp_ext  = (AW+1)'(wp_q) + DEPTH_X;
    rd_pos  = {wp_ext, 16'h0000} - (AW+17)'(delay_c);
    rd_int  = rd_pos[AW+16:16];
    rd_wrap = (rd_int >= DEPTH_X) ? rd_int - DEPTH_X : rd_int;
  end

  // operand selection for the multiply-accumulate unit
  always_comb begin
    mac_req = '0;
    case (state_q)
      S_GLIDE: begin
        mac_req.en   = 1'b1;
        mac_req.load = 1'b1;
        mac_req.bias = MAC_ACC_W'(ROUND_HALF);
        mac_req.x    = glide_diff;
        mac_req.y    = MAC_Y_W'(GLIDE_STEP);
      end
      S_IL: begin
        mac_req.en   = 1'b1;
        mac_req.load = 1'b1;
        mac_req.bias = {(MAC_ACC_W-16)'(a_l_q), 16'h0000};
        mac_req.x    = MAC_X_W'(dif_l_q);
        mac_req.y    = {2'b00, frac_q};
      end
      S_IR: begin
        mac_req.en   = 1'b1;
        mac_req.load = 1'b1;
        mac_req.bias = {(MAC_ACC_W-16)'(a_r_q), 16'h0000};
        mac_req.x    = MAC_X_W'(dif_r_q);
        mac_req.y    = {2'b00, frac_q};
      end
      S_OL0: begin
        mac_req.en   = 1'b1;
        mac_req.load = 1'b1;
        mac_req.x    = MAC_X_W'(dry_l_q);
        mac_req.y    = {1'b0, wet_inv};
      end
      S_OL1: begin
        mac_req.en = 1'b1;
        mac_req.x  = MAC_X_W'(del_l_q);
        mac_req.y  = {1'b0, wet_eff};
      end
      S_OR0: begin
        mac_req.en   = 1'b1;
        mac_req.load = 1'b1;
        mac_req.x    = MAC_X_W'(dry_r_q);
        mac_req.y    = {1'b0, wet_inv};
      end
      S_OR1: begin
        mac_req.en = 1'b1;
        mac_req.x  = MAC_X_W'(del_r_q);
        mac_req.y  = {1'b0, wet_eff};
      end
      S_DL0: begin
        mac_req.en   = 1'b1;
        mac_req.load = 1'b1;
        mac_req.x    = MAC_X_W'(fed_l);
        mac_req.y    = {1'b0, damp_inv};
      end
      S_DL1: begin
        mac_req.en = 1'b1;
        mac_req.x  = MAC_X_W'(dmp_l_q);
        mac_req.y  = {1'b0, damp_eff};
      end
      S_DR0: begin
        mac_req.en   = 1'b1;
        mac_req.load = 1'b1;
        mac_req.x    = MAC_X_W'(fed_r);
        mac_req.y    = {1'b0, damp_inv};
      end
      S_DR1: begin
        mac_req.en = 1'b1;
        mac_req.x  = MAC_X_W'(dmp_r_q);
        mac_req.y  = {1'b0, damp_eff};
      end
      S_FL: begin
        mac_req.en   = 1'b1;
        mac_req.load = 1'b1;
        mac_req.bias = {(MAC_ACC_W-16)'(dry_l_q), 16'h0000};
        mac_req.x    = MAC_X_W'(dmp_l_q);
        mac_req.y    = {2'b00, fbg_q};
      end
      S_FR: begin
        mac_req.en   = 1'b1;
        mac_req.load = 1'b1;
        mac_req.bias = {(MAC_ACC_W-16)'(dry_r_q), 16'h0000};
        mac_req.x    = MAC_X_W'(dmp_r_q);
        mac_req.y    = {2'b00, fbg_q};
      end
      default: ;
    endcase
  end

  sfd_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .acc_o (acc)
  );

  // line access: clearing sweep, then echo write-back at the write pointer
  always_comb begin
    we_l    = 1'b0;
    we_r    = 1'b0;
    waddr   = wp_q;
    wdata_l = acc_sat;
    wdata_r = acc_sat;
    raddr   = (state_q == S_RD1) ? rj_q : ri_q;
    case (state_q)
      S_CLEAR: begin
        we_l    = 1'b1;
        we_r    = 1'b1;
        waddr   = clr_q;
        wdata_l = '0;
        wdata_r = '0;
      end
      S_FR: we_l = 1'b1;
      S_WB: we_r = 1'b1;
      default: ;
    endcase
  end

  sfd_line #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_line_l (
    .clk_i   (clk_i),
    .we_i    (we_l),
    .waddr_i (waddr),
    .wdata_i (wdata_l),
    .raddr_i (raddr),
    .rdata_o (rdata_l)
  );

  sfd_line #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_line_r (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (waddr),
    .wdata_i (wdata_r),
    .raddr_i (raddr),
    .rdata_o (rdata_r)
  );

  // sequencer
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    wp_d        = wp_q;
    glided_d    = glided_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_GLIDE;
        end
      end
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_GLIDE: state_d = S_ADJ;
      S_ADJ: begin
        glided_d = glided_q + acc_shr[31:0];
        state_d  = S_ADDR;
      end
      S_ADDR: state_d = S_RD0;
      S_RD0:  state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_IL;
      S_IL:   state_d = S_IR;
      S_IR:   state_d = S_OL0;
      S_OL0:  state_d = S_OL1;
      S_OL1:  state_d = S_OR0;
      S_OR0:  state_d = S_OR1;
      S_OR1:  state_d = S_DL0;
      S_DL0:  state_d = S_DL1;
      S_DL1:  state_d = S_DR0;
      S_DR0:  state_d = S_DR1;
      S_DR1:  state_d = S_FL;
      S_FL:   state_d = S_FR;
      S_FR:   state_d = S_WB;
      S_WB: begin
        wp_d    = (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      wp_q        <= '0;
      glided_q    <= DELAY_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wp_q        <= wp_d;
      glided_q    <= glided_d;
      out_valid_q <= out_valid_d;
    end
  end

  // lowpass states in the feedback path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmp_l_q <= '0;
      dmp_r_q <= '0;
    end else begin
      if (state_q == S_DR0) begin
        dmp_l_q <= acc_shr[SB-1:0];
      end
      if (state_q == S_FL) begin
        dmp_r_q <= acc_shr[SB-1:0];
      end
    end
  end

  // frame datapath registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      dry_l_q <= in_i.left_in;
      dry_r_q <= in_i.right_in;
    end
    if (state_q == S_ADDR) begin
      ri_q   <= rd_wrap[AW-1:0];
      frac_q <= rd_pos[15:0];
    end
    if (state_q == S_RD0) begin
      rj_q <= (ri_q == LAST_ADDR) ? '0 : ri_q + AW'(1);
    end
    if (state_q == S_RD1) begin
      a_l_q <= rdata_l;
      a_r_q <= rdata_r;
    end
    if (state_q == S_RD2) begin
      dif_l_q <= $signed({rdata_l[SB-1], rdata_l}) - $signed({a_l_q[SB-1], a_l_q});
      dif_r_q <= $signed({rdata_r[SB-1], rdata_r}) - $signed({a_r_q[SB-1], a_r_q});
    end
    if (state_q == S_IR) begin
      del_l_q <= acc_shr[SB-1:0];
    end
    if (state_q == S_OL0) begin
      del_r_q <= acc_shr[SB-1:0];
    end
    if (state_q == S_OR0) begin
      res_l_q <= acc_sat;
    end
    if (state_q == S_DL0) begin
      res_r_q <= acc_sat;
    end
    if (state_q == S_DONE && out_free) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
    end
  end

  // ports
  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;

`ifndef SYNTH
  a_accept_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_GLIDE))
    else $error("accepted item did not start the glide step");

  a_read_behind_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0) |-> (ri_q != wp_q))
    else $error("interpolation read hits the write pointer");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result shown outside the done step");
`endif

endmodule
